/* hdl/mssd_pkg.sv */
// Package for the multiplexed seven-segment driver.
// Holds field widths, item codes, the divide-by-ten constants and the segment code table.
// No dependencies.
package mssd_pkg;

	localparam int VALUE_W = 16;
	localparam int DIG_W = 4;
	localparam int SEG_W = 8;
	localparam int EN_W = 4;
	localparam int DWELL_W = 16;
	localparam int STATIC_DIGITS = 4;
	localparam int OUT_W = 48;
	localparam int QUEUE_DEPTH = 2;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd50;

	// Exact quotient by ten for any 16-bit value: (x * 52429) >> 19.
	localparam int RECIP_W = 17;
	localparam logic [RECIP_W-1:0] RECIP_TEN = 17'd52429;
	localparam int RECIP_SHIFT = 19;

	localparam logic [SEG_W-1:0] SEG_OFF = 8'hFF;

	function automatic logic [SEG_W-1:0] seg_code(input logic [DIG_W-1:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 8'hC0;
			4'd1: s = 8'hF9;
			4'd2: s = 8'hA4;
			4'd3: s = 8'hB0;
			4'd4: s = 8'h99;
			4'd5: s = 8'h92;
			4'd6: s = 8'h82;
			4'd7: s = 8'hF8;
			4'd8: s = 8'h80;
			4'd9: s = 8'h90;
			default: s = SEG_OFF;
		endcase
		return s;
	endfunction

endpackage

/* hdl/mssd_front.sv */
// Front end of the seven-segment driver: accepts items and splits loaded values into
// decimal digits, one divide-by-ten stage per digit. Depends on mssd_pkg.
module mssd_front #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	input  logic [mssd_pkg::VALUE_W-1:0]               s_tdata,
	input  logic                                       s_tuser,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic                                       out_mode,
	output logic [DIGIT_COUNT*mssd_pkg::DIG_W-1:0]     out_digits
);
	import mssd_pkg::*;

	localparam int DIGS_W = DIGIT_COUNT * DIG_W;
	localparam int PROD_W = VALUE_W + RECIP_W;

	logic               vld_s   [DIGIT_COUNT];
	logic               mode_s  [DIGIT_COUNT];
	logic [VALUE_W-1:0] quot_s  [DIGIT_COUNT];
	logic [DIGS_W-1:0]  dig_s   [DIGIT_COUNT];

	logic               v_in    [DIGIT_COUNT];
	logic               m_in    [DIGIT_COUNT];
	logic [VALUE_W-1:0] q_in    [DIGIT_COUNT];
	logic [DIGS_W-1:0]  d_in    [DIGIT_COUNT];
	logic               en;

	assign en = !vld_s[DIGIT_COUNT-1] || out_ready;
	assign s_tready = en;
	assign out_valid = vld_s[DIGIT_COUNT-1];
	assign out_mode = mode_s[DIGIT_COUNT-1];
	assign out_digits = dig_s[DIGIT_COUNT-1];

	for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_stage
		logic [PROD_W-1:0]  prod;
		logic [VALUE_W-1:0] quot;
		logic [VALUE_W-1:0] rem;
		logic [DIGS_W-1:0]  d_next;

		if (g == 0) begin : g_first
			assign v_in[g] = s_tvalid;
			assign m_in[g] = s_tuser;
			assign q_in[g] = s_tdata;
			assign d_in[g] = '0;
		end else begin : g_next
			assign v_in[g] = vld_s[g-1];
			assign m_in[g] = mode_s[g-1];
			assign q_in[g] = quot_s[g-1];
			assign d_in[g] = dig_s[g-1];
		end

		always_comb begin
			prod = PROD_W'(q_in[g]) * PROD_W'(RECIP_TEN);
			quot = VALUE_W'(prod >> RECIP_SHIFT);
			rem = q_in[g] - ((quot << 3) + (quot << 1));
			d_next = d_in[g];
			d_next[g*DIG_W +: DIG_W] = rem[DIG_W-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= v_in[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mode_s[g] <= m_in[g];
				quot_s[g] <= quot;
				dig_s[g] <= d_next;
			end
		end
	end

endmodule

/* hdl/mssd_queue.sv */
// Two-entry queue between the front end and the back end of the seven-segment driver.
// Depends on mssd_pkg for its depth.
module mssd_queue #(
	parameter int WIDTH = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);
	import mssd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign in_ready = cnt_q != CNT_W'(QUEUE_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data = mem_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

/* hdl/mssd_back.sv */
// Back end of the seven-segment driver: holds the digits, dwell counter and scan position,
// and drives the registered result transfer. Depends on mssd_pkg.
module mssd_back #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   in_mode,
	input  logic [DIGIT_COUNT*mssd_pkg::DIG_W-1:0] in_digits,
	input  logic [mssd_pkg::DWELL_W-1:0]           dwell_ticks,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [mssd_pkg::OUT_W-1:0]             m_tdata
);
	import mssd_pkg::*;

	localparam int DIGS_W = DIGIT_COUNT * DIG_W;
	localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

	logic [DIGS_W-1:0]  store_q;
	logic [DIGS_W-1:0]  store_n;
	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   pos_n;
	logic [DWELL_W-1:0] cnt_q;
	logic [DWELL_W-1:0] cnt_n;
	logic [DWELL_W-1:0] cnt_inc;
	logic [DWELL_W-1:0] limit;
	logic [DIG_W-1:0]   scan_dig;
	logic [DIG_W-1:0]   st_dig [STATIC_DIGITS];
	logic [EN_W-1:0]    en_n;
	logic [OUT_W-1:0]   data_n;
	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;
	logic               pop;

	assign in_ready = !m_tvalid_q || m_tready;
	assign pop = in_valid && in_ready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	always_comb begin
		limit = (dwell_ticks == '0) ? DWELL_W'(1) : dwell_ticks;
		cnt_inc = DWELL_W'(cnt_q + 1'b1);
		store_n = store_q;
		pos_n = pos_q;
		cnt_n = cnt_q;
		if (in_mode == MODE_LOAD) begin
			store_n = in_digits;
			cnt_n = '0;
			pos_n = '0;
		end else if (cnt_inc >= limit) begin
			cnt_n = '0;
			if (pos_q == POS_W'(DIGIT_COUNT - 1)) begin
				pos_n = '0;
			end else begin
				pos_n = POS_W'(pos_q + 1'b1);
			end
		end else begin
			cnt_n = cnt_inc;
		end
	end

	for (genvar k = 0; k < STATIC_DIGITS; k++) begin : g_static
		if (k < DIGIT_COUNT) begin : g_have
			assign st_dig[k] = store_n[k*DIG_W +: DIG_W];
		end else begin : g_none
			assign st_dig[k] = '0;
		end
	end

	always_comb begin
		scan_dig = store_n[pos_n*DIG_W +: DIG_W];
		en_n = ~(EN_W'(1) << pos_n);
		data_n = {4'b0000, seg_code(st_dig[3]), seg_code(st_dig[2]), seg_code(st_dig[1]),
			seg_code(st_dig[0]), en_n, seg_code(scan_dig)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
			pos_q <= '0;
			cnt_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				store_q <= store_n;
				pos_q <= pos_n;
				cnt_q <= cnt_n;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			m_tdata_q <= data_n;
		end
	end

endmodule

/* hdl/multiplexed_seven_segment_driver.sv */
// Multiplexed seven-segment display driver, top level; uses mssd_pkg, mssd_front,
// mssd_queue and mssd_back.
// Throughput is one transfer per cycle while m_tready keeps up with results. m_tvalid for a
// result rises once its input transfer has passed DIGIT_COUNT divide-by-ten stages, the
// first loaded by the transfer itself, then one queue slot and one output register.
// Asynchronous reset clears the pipeline and queue, sets the stored digits to "0000" with the
// scan at units, clears the dwell counter and sets dwell_ticks to 50.
module multiplexed_seven_segment_driver #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// value
	input  logic [mssd_pkg::VALUE_W-1:0]   s_tdata,
	// mode
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// scan_segments, digit_enable_n, static_units, static_tens, static_hundreds,
	// static_thousands, zero padding
	output logic [mssd_pkg::OUT_W-1:0]     m_tdata,
	input  logic                           cfg_we,
	input  logic [mssd_pkg::DWELL_W-1:0]   cfg_wdata
);
	import mssd_pkg::*;

	localparam int DIGS_W = DIGIT_COUNT * DIG_W;
	localparam int Q_W = DIGS_W + 1;

	logic               front_valid;
	logic               front_ready;
	logic               front_mode;
	logic [DIGS_W-1:0]  front_digits;
	logic               q_out_valid;
	logic               q_out_ready;
	logic [Q_W-1:0]     q_out_data;
	logic [DWELL_W-1:0] dwell_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_q <= DWELL_RESET;
		end else if (cfg_we) begin
			dwell_q <= cfg_wdata;
		end
	end

	mssd_front #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_mode  (front_mode),
		.out_digits(front_digits)
	);

	mssd_queue #(
		.WIDTH(Q_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (front_valid),
		.in_ready (front_ready),
		.in_data  ({front_digits, front_mode}),
		.out_valid(q_out_valid),
		.out_ready(q_out_ready),
		.out_data (q_out_data)
	);

	mssd_back #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (q_out_valid),
		.in_ready   (q_out_ready),
		.in_mode    (q_out_data[0]),
		.in_digits  (q_out_data[Q_W-1:1]),
		.dwell_ticks(dwell_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	a_one_enable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones(~m_tdata[11:8]) <= 1)
		else $error("more than one digit enable is active");

	a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !(q_out_valid && q_out_ready))
		else $error("back end took an item while the result was stalled");

	a_front_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(front_valid && !front_ready) |=> front_valid)
		else $error("front end dropped an item while the queue was full");

endmodule

/* bench/multiplexed_seven_segment_driver_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the multiplexed seven-segment display driver.
// Drives loads and ticks over the input stream, predicts every result in its own model of
// the digit store, scan position and dwell counter, and depends only on the RTL and mssd_pkg.
module multiplexed_seven_segment_driver_tb;

	// Field order matches m_tdata, first member in the highest bits.
	typedef struct packed {
		logic [3:0] pad;
		logic [7:0] static_thousands;
		logic [7:0] static_hundreds;
		logic [7:0] static_tens;
		logic [7:0] static_units;
		logic [3:0] digit_enable_n;
		logic [7:0] scan_segments;
	} display_t;

	typedef enum logic {ROW_ITEM, ROW_DWELL} row_kind_e;
	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

	typedef struct {
		row_kind_e kind;
		logic mode;
		logic [15:0] data;
		bit typed;
		display_t want;
	} row_t;

	localparam int DIGITS = 4;
	localparam int SETTLE_CYCLES = DIGITS + 4;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 195;

	localparam logic [7:0] GLYPHS [10] = '{
		8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
	};
	localparam logic [15:0] PHASE_DWELL [4] = '{16'd1, 16'd3, 16'd2, 16'd0};

	localparam display_t SHOW_0000 = 48'h0_C0_C0_C0_C0_E_C0;
	localparam display_t SHOW_5535 = 48'h0_92_92_B0_92_E_92;
	localparam display_t SHOW_9999 = 48'h0_90_90_90_90_E_90;
	localparam display_t UNTYPED = '0;

	localparam logic LOAD = mssd_pkg::MODE_LOAD;
	localparam logic TICK = mssd_pkg::MODE_TICK;

	row_t directed_rows [25] = '{
		'{ROW_ITEM, TICK, 16'd0, 1'b1, SHOW_0000},
		'{ROW_ITEM, LOAD, 16'd0, 1'b1, SHOW_0000},
		'{ROW_ITEM, LOAD, 16'd65535, 1'b1, SHOW_5535},
		'{ROW_ITEM, LOAD, 16'd9999, 1'b1, SHOW_9999},
		'{ROW_ITEM, LOAD, 16'd10000, 1'b1, SHOW_0000},
		'{ROW_ITEM, LOAD, 16'd1234, 1'b0, UNTYPED},
		'{ROW_ITEM, LOAD, 16'd5678, 1'b0, UNTYPED},
		'{ROW_DWELL, LOAD, 16'd0, 1'b0, UNTYPED},
		'{ROW_ITEM, TICK, 16'hFFFF, 1'b0, UNTYPED},
		'{ROW_ITEM, TICK, 16'h0000, 1'b0, UNTYPED},
		'{ROW_ITEM, TICK, 16'hAAAA, 1'b0, UNTYPED},
		'{ROW_ITEM, TICK, 16'h5555, 1'b0, UNTYPED},
		'{ROW_ITEM, TICK, 16'hFFFF, 1'b0, UNTYPED},
		'{ROW_ITEM, LOAD, 16'd4321, 1'b0, UNTYPED},
		'{ROW_DWELL, LOAD, 16'd1, 1'b0, UNTYPED},
		'{ROW_ITEM, TICK, 16'd0, 1'b0, UNTYPED},
		'{ROW_ITEM, TICK, 16'd0, 1'b0, UNTYPED},
		'{ROW_ITEM, TICK, 16'd0, 1'b0, UNTYPED},
		'{ROW_DWELL, LOAD, 16'd3, 1'b0, UNTYPED},
		'{ROW_ITEM, TICK, 16'd0, 1'b0, UNTYPED},
		'{ROW_ITEM, TICK, 16'd0, 1'b0, UNTYPED},
		'{ROW_ITEM, TICK, 16'd0, 1'b0, UNTYPED},
		'{ROW_ITEM, TICK, 16'd0, 1'b0, UNTYPED},
		'{ROW_DWELL, LOAD, 16'd65535, 1'b0, UNTYPED},
		'{ROW_ITEM, TICK, 16'd0, 1'b0, UNTYPED}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [mssd_pkg::VALUE_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [mssd_pkg::OUT_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [mssd_pkg::DWELL_W-1:0] cfg_wdata = '0;

	int fail_count = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	idle_mode_e idle_mode = IDLE_NONE;
	display_t pending_displays [$];

	logic [3:0] shown_digits [DIGITS] = '{4'd0, 4'd0, 4'd0, 4'd0};
	logic [1:0] scan_pos = 2'd0;
	logic [15:0] dwell_cnt = 16'd0;
	logic [15:0] dwell_setting = mssd_pkg::DWELL_RESET;

	always #5 clk = ~clk;

	multiplexed_seven_segment_driver #(
		.DIGIT_COUNT(DIGITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	function display_t next_display(input logic mode, input logic [15:0] value);
		display_t d;
		int rest;
		logic [15:0] limit;
		d = '0;
		if (mode == LOAD) begin
			rest = value;
			for (int i = 0; i < DIGITS; i++) begin
				shown_digits[i] = 4'(rest % 10);
				rest = rest / 10;
			end
			dwell_cnt = 16'd0;
			scan_pos = 2'd0;
		end else begin
			limit = (dwell_setting == 16'd0) ? 16'd1 : dwell_setting;
			dwell_cnt = dwell_cnt + 16'd1;
			if (dwell_cnt >= limit) begin
				dwell_cnt = 16'd0;
				scan_pos = scan_pos + 2'd1;
			end
		end
		d.scan_segments = GLYPHS[shown_digits[scan_pos]];
		d.digit_enable_n = ~(4'b0001 << scan_pos);
		d.static_units = GLYPHS[shown_digits[0]];
		d.static_tens = GLYPHS[shown_digits[1]];
		d.static_hundreds = GLYPHS[shown_digits[2]];
		d.static_thousands = GLYPHS[shown_digits[3]];
		return d;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic send_item(input logic mode, input logic [15:0] value, input bit typed,
			input display_t want);
		display_t predicted;
		int pct;
		pct = (idle_mode == IDLE_SENDER) ? 52 : (idle_mode == IDLE_BOTH) ? 33 : 0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 99) < pct) begin
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tuser <= mode;
				s_tdata <= value;
				do @(posedge clk); while (!s_tready);
				predicted = next_display(mode, value);
				pending_displays.push_back(typed ? want : predicted);
				return;
			end
		end
	endtask

	task automatic set_dwell(input logic [15:0] ticks);
		@(negedge clk) s_tvalid <= 1'b0;
		while (pending_displays.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= ticks;
		@(posedge clk);
		dwell_setting = ticks;
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	initial begin : receiver
		display_t got;
		display_t want;
		int pct;
		forever begin
			@(negedge clk);
			pct = (idle_mode == IDLE_RECEIVER) ? 52 : (idle_mode == IDLE_BOTH) ? 33 : 0;
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= pct);
			end
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got = m_tdata;
				if (pending_displays.size() == 0) begin
					$error("result transfer with no expectation waiting: 0x%0h", got);
					fail_count++;
				end else begin
					want = pending_displays.pop_front();
					check_field("scan_segments", want.scan_segments, got.scan_segments);
					check_field("digit_enable_n", want.digit_enable_n, got.digit_enable_n);
					check_field("static_units", want.static_units, got.static_units);
					check_field("static_tens", want.static_tens, got.static_tens);
					check_field("static_hundreds", want.static_hundreds, got.static_hundreds);
					check_field("static_thousands", want.static_thousands,
						got.static_thousands);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("multiplexed_seven_segment_driver_tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		row_t row;
		logic [15:0] word;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_DWELL) begin
				set_dwell(row.data);
			end else begin
				send_item(row.mode, row.data, row.typed, row.want);
			end
		end

		for (int p = 0; p < 4; p++) begin
			set_dwell(PHASE_DWELL[p]);
			idle_mode = idle_mode_e'(p);
			// The long receiver hold-off fills the pipeline and queue so the input stalls.
			if (idle_mode == IDLE_NONE) begin
				hold_left = HOLD_CYCLES;
			end
			repeat (PHASE_ITEMS) begin
				word = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
					: 16'($urandom_range(0, 9999));
				if ($urandom_range(0, 9) == 0) begin
					send_item(LOAD, word, 1'b0, UNTYPED);
				end else begin
					send_item(TICK, word, 1'b0, UNTYPED);
				end
			end
		end

		@(negedge clk) s_tvalid <= 1'b0;
		while (pending_displays.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("multiplexed_seven_segment_driver_tb: done, clean");
		end else begin
			$display("multiplexed_seven_segment_driver_tb: done, errors");
		end
		$finish;
	end

endmodule

/* files.f */
hdl/mssd_pkg.sv
hdl/mssd_front.sv
hdl/mssd_queue.sv
hdl/mssd_back.sv
hdl/multiplexed_seven_segment_driver.sv
bench/multiplexed_seven_segment_driver_tb.sv
